### hw/rtl/prt_pkg.sv
package prt_pkg;

  // Default geometry of the peer table.
  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned PeerIdBitsDef   = 48;

  // Configuration port geometry.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Fixed field widths.
  localparam int unsigned OpW     = 3;
  localparam int unsigned RateW   = 16;
  localparam int unsigned MinW    = 15;
  localparam int unsigned RttW    = 32;
  localparam int unsigned StatusW = 2;

  // One in Q0.16, held one bit wider than a rate.
  localparam logic [RateW:0] OneQ16 = 17'h10000;

  // Register reset values.
  localparam logic [RateW-1:0] WeightRst  = 16'd6554;
  localparam logic [MinW-1:0]  MinRateRst = 15'd655;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WEIGHT   = 2'd0,
    CFG_MIN_RATE = 2'd1
  } cfg_idx_e;

  typedef enum logic [OpW-1:0] {
    OP_ADD    = 3'd0,
    OP_DELETE = 3'd1,
    OP_RECV   = 3'd2,
    OP_TMO    = 3'd3,
    OP_RTT    = 3'd4,
    OP_QUERY  = 3'd5
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // Outcome of the associative search over the table.
  typedef struct packed {
    logic hit;
    logic full;
  } lookup_t;

endpackage

### hw/rtl/prt_if.sv
interface prt_req_if #(
  parameter int unsigned ID_BITS = prt_pkg::PeerIdBitsDef
);
  logic                       valid;
  logic                       ready;
  logic [prt_pkg::OpW-1:0]    op;
  logic [ID_BITS-1:0]         peer_id;
  logic [prt_pkg::RttW-1:0]   rtt_sample;

  modport source (output valid, output op, output peer_id, output rtt_sample,
                  input ready);
  modport sink   (input valid, input op, input peer_id, input rtt_sample,
                  output ready);
endinterface

interface prt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [prt_pkg::StatusW-1:0]  status;
  logic [prt_pkg::RateW-1:0]    rate;
  logic [prt_pkg::RttW-1:0]     rtt;
  logic                         rtt_valid;

  modport source (output valid, output status, output rate, output rtt,
                  output rtt_valid, input ready);
  modport sink   (input valid, input status, input rate, input rtt,
                  input rtt_valid, output ready);
endinterface

### hw/rtl/prt_match.sv
module prt_match #(
  parameter int unsigned ENTRIES = prt_pkg::TableEntriesDef,
  parameter int unsigned ID_BITS = prt_pkg::PeerIdBitsDef,
  localparam int unsigned IdxW   = $clog2(ENTRIES)
) (
  input  logic [ENTRIES-1:0] valid_i,
  input  logic [ID_BITS-1:0] keys_i [ENTRIES],
  input  logic [ID_BITS-1:0] key_i,
  output logic [ENTRIES-1:0] hit_vec_o,
  output logic [IdxW-1:0]    hit_idx_o,
  output logic [IdxW-1:0]    free_idx_o,
  output prt_pkg::lookup_t   lookup_o
);
  import prt_pkg::*;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec_o[i] = valid_i[i] && (keys_i[i] == key_i);
    end
  end

  // At most one entry matches, so an OR of the indexes encodes it.
  always_comb begin
    hit_idx_o = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec_o[i]) begin
        hit_idx_o = hit_idx_o | IdxW'(i);
      end
    end
  end

  // Lowest free entry wins.
  always_comb begin
    free_idx_o = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_i[i]) begin
        free_idx_o = IdxW'(i);
      end
    end
  end

  assign lookup_o.hit  = |hit_vec_o;
  assign lookup_o.full = &valid_i;

endmodule

### hw/rtl/prt_update.sv
module prt_update (
  input  logic [prt_pkg::RateW-1:0] weight_i,
  input  logic [prt_pkg::MinW-1:0]  min_rate_i,
  input  logic [prt_pkg::RateW-1:0] rate_i,
  input  logic [prt_pkg::RttW-1:0]  rtt_i,
  input  logic [prt_pkg::RttW-1:0]  sample_i,
  output logic [prt_pkg::RateW-1:0] ceil_o,
  output logic [prt_pkg::RateW-1:0] rate_recv_o,
  output logic [prt_pkg::RateW-1:0] rate_tmo_o,
  output logic [prt_pkg::RttW-1:0]  rtt_avg_o
);
  import prt_pkg::*;

  logic [RateW:0]       keep;
  logic [RateW:0]       ceil_full;
  logic [2*RateW:0]     rate_prod;
  logic [RateW-1:0]     rate_scaled;
  logic [RateW:0]       recv_sum;
  logic [RttW+RateW-1:0] samp_prod;
  logic [RttW+RateW:0]  rtt_prod;
  logic [RttW+RateW+1:0] rtt_acc;

  assign keep      = OneQ16 - (RateW + 1)'(weight_i);
  assign ceil_full = OneQ16 - (RateW + 1)'(min_rate_i);
  assign ceil_o    = ceil_full[RateW] ? '1 : ceil_full[RateW-1:0];

  // The product never exceeds the old rate, so sixteen bits hold it.
  assign rate_prod   = (2*RateW + 1)'(rate_i) * (2*RateW + 1)'(keep);
  assign rate_scaled = rate_prod[2*RateW-1:RateW];

  assign recv_sum    = (RateW + 1)'(weight_i) + (RateW + 1)'(rate_scaled);
  assign rate_recv_o = (recv_sum > (RateW + 1)'(ceil_o)) ? ceil_o
                                                         : recv_sum[RateW-1:0];
  assign rate_tmo_o  = (rate_scaled < RateW'(min_rate_i)) ? RateW'(min_rate_i)
                                                          : rate_scaled;

  assign samp_prod = (RttW + RateW)'(sample_i) * (RttW + RateW)'(weight_i);
  assign rtt_prod  = (RttW + RateW + 1)'(rtt_i) * (RttW + RateW + 1)'(keep);
  assign rtt_acc   = (RttW + RateW + 2)'(samp_prod) + (RttW + RateW + 2)'(rtt_prod);
  assign rtt_avg_o = rtt_acc[RttW+RateW-1:RateW];

endmodule

### hw/rtl/peer_rate_ewma_table_core.sv
// Peer rate table. Each peer is found by its identifier in a fully
// associative table and holds an exponentially weighted reception rate
// (Q0.16) and a smoothed round-trip estimate in microseconds. A transaction
// on req_i carries one operation (add, delete, reception, timeout,
// round-trip sample or query; unused codes act as a query) and yields
// exactly one transaction on rsp_o with a status and the peer's values after
// the operation. The block takes one transaction per cycle while rsp_o is
// not back-pressured: an accepted request is held in an input register,
// and a single combinational pass (the key search, the multiply and add,
// the clamp) then updates the table and loads the result register, from which
// the result is offered. Back-pressure on rsp_o holds the result register
// and, once the input register is occupied as well, the request side too.
// Writes to the weight and floor registers are meant for idle periods only.
module peer_rate_ewma_table_core #(
  parameter int unsigned TABLE_ENTRIES = prt_pkg::TableEntriesDef,
  parameter int unsigned PEER_ID_BITS  = prt_pkg::PeerIdBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  prt_req_if.sink                       req_i,
  prt_rsp_if.source                     rsp_o,
  input  logic                          cfg_we_i,
  input  logic [prt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [prt_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import prt_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);

  // Configuration registers.
  logic [RateW-1:0] weight_q;
  logic [MinW-1:0]  min_rate_q;

  // Input register.
  logic                    s1_valid_q;
  logic [OpW-1:0]          s1_op_q;
  logic [PEER_ID_BITS-1:0] s1_id_q;
  logic [RttW-1:0]         s1_sample_q;

  // Peer table: keys and values are flops read through the match index.
  logic [PEER_ID_BITS-1:0]  key_q [TABLE_ENTRIES];
  logic [RateW-1:0]         rate_q [TABLE_ENTRIES];
  logic [RttW-1:0]          rtt_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [TABLE_ENTRIES-1:0] rttv_q;

  // Result register.
  logic             out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [RateW-1:0] out_rate_q;
  logic [RttW-1:0]  out_rtt_q;
  logic             out_rttv_q;

  logic                     s1_adv;
  logic                     fire;
  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic [IdxW-1:0]          hit_idx;
  logic [IdxW-1:0]          free_idx;
  lookup_t                  lookup;

  logic [RateW-1:0] ceil_rate;
  logic [RateW-1:0] rate_recv;
  logic [RateW-1:0] rate_tmo;
  logic [RttW-1:0]  rtt_avg;
  logic [RateW-1:0] rate_cur;
  logic [RttW-1:0]  rtt_cur;
  logic             rttv_cur;

  logic             wr_new;
  logic             wr_del;
  logic             wr_rate;
  logic             wr_rtt;
  logic [RateW-1:0] rate_nxt;
  logic [RttW-1:0]  rtt_nxt;
  status_e          res_status;
  logic [RateW-1:0] res_rate;
  logic [RttW-1:0]  res_rtt;
  logic             res_rttv;

  // The pass from the input register may run whenever the result register
  // is empty or is being emptied in this cycle.
  assign s1_adv      = !out_valid_q || rsp_o.ready;
  assign fire        = s1_valid_q && s1_adv;
  assign req_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q   <= WeightRst;
      min_rate_q <= MinRateRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WEIGHT:   weight_q   <= cfg_wdata_i;
        CFG_MIN_RATE: min_rate_q <= cfg_wdata_i[MinW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_op_q     <= req_i.op;
      s1_id_q     <= req_i.peer_id;
      s1_sample_q <= req_i.rtt_sample;
    end
  end

  prt_match #(
    .ENTRIES (TABLE_ENTRIES),
    .ID_BITS (PEER_ID_BITS)
  ) u_match (
    .valid_i    (valid_q),
    .keys_i     (key_q),
    .key_i      (s1_id_q),
    .hit_vec_o  (hit_vec),
    .hit_idx_o  (hit_idx),
    .free_idx_o (free_idx),
    .lookup_o   (lookup)
  );

  assign rate_cur = rate_q[hit_idx];
  assign rtt_cur  = rtt_q[hit_idx];
  assign rttv_cur = rttv_q[hit_idx];

  prt_update u_update (
    .weight_i    (weight_q),
    .min_rate_i  (min_rate_q),
    .rate_i      (rate_cur),
    .rtt_i       (rtt_cur),
    .sample_i    (s1_sample_q),
    .ceil_o      (ceil_rate),
    .rate_recv_o (rate_recv),
    .rate_tmo_o  (rate_tmo),
    .rtt_avg_o   (rtt_avg)
  );

  // Operation decode. The result reports the peer as it stands after the
  // operation; an absent peer, a refused add and a delete report zeros.
  always_comb begin
    wr_new     = 1'b0;
    wr_del     = 1'b0;
    wr_rate    = 1'b0;
    wr_rtt     = 1'b0;
    rate_nxt   = rate_cur;
    rtt_nxt    = rtt_cur;
    res_status = ST_OK;
    res_rate   = '0;
    res_rtt    = '0;
    res_rttv   = 1'b0;
    if (s1_op_q == OP_ADD) begin
      if (lookup.hit) begin
        res_rate = rate_cur;
        res_rtt  = rttv_cur ? rtt_cur : '0;
        res_rttv = rttv_cur;
      end else if (lookup.full) begin
        res_status = ST_FULL;
      end else begin
        wr_new   = 1'b1;
        res_rate = ceil_rate;
      end
    end else if (!lookup.hit) begin
      res_status = ST_NOT_FOUND;
    end else begin
      unique case (op_e'(s1_op_q))
        OP_DELETE: wr_del = 1'b1;
        OP_RECV: begin
          wr_rate  = 1'b1;
          rate_nxt = rate_recv;
        end
        OP_TMO: begin
          wr_rate  = 1'b1;
          rate_nxt = rate_tmo;
        end
        OP_RTT: begin
          wr_rtt  = 1'b1;
          rtt_nxt = rttv_cur ? rtt_avg : s1_sample_q;
        end
        default: ;
      endcase
      if (!wr_del) begin
        res_rate = rate_nxt;
        res_rttv = rttv_cur || wr_rtt;
        res_rtt  = res_rttv ? rtt_nxt : '0;
      end
    end
  end

  // Valid bits of the table carry the reset; the payload does not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rttv_q  <= '0;
    end else if (fire) begin
      if (wr_new) begin
        valid_q[free_idx] <= 1'b1;
        rttv_q[free_idx]  <= 1'b0;
      end
      if (wr_del) begin
        valid_q[hit_idx] <= 1'b0;
        rttv_q[hit_idx]  <= 1'b0;
      end
      if (wr_rtt) begin
        rttv_q[hit_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (wr_new) begin
        key_q[free_idx]  <= s1_id_q;
        rate_q[free_idx] <= ceil_rate;
      end
      if (wr_rate) begin
        rate_q[hit_idx] <= rate_nxt;
      end
      if (wr_rtt) begin
        rtt_q[hit_idx] <= rtt_nxt;
      end
    end
  end

  // Result register: parts the table pass from the consumer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_status_q <= res_status;
      out_rate_q   <= res_rate;
      out_rtt_q    <= res_rtt;
      out_rttv_q   <= res_rttv;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.rate      = out_rate_q;
  assign rsp_o.rtt       = out_rtt_q;
  assign rsp_o.rtt_valid = out_rttv_q;

`ifndef SYNTHESIS
  // A peer is never held in two entries.
  a_unique_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $onehot0(hit_vec))
    else $error("peer found in more than one table entry");

  // A successful add leaves the chosen entry occupied.
  a_add_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && wr_new |=> valid_q[$past(free_idx)])
    else $error("added peer did not occupy its entry");

  // The table only changes when a request passes to the result register.
  a_table_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(valid_q) && $stable(rttv_q))
    else $error("table occupancy changed without a request");

  // Every request that passes produces a result.
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("request passed without a result");
`endif

endmodule
